FILE: sv/crc32bh_pkg.sv
// Shared widths and constants for the byte-serial CRC-32 hash core.
package crc32bh_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned CrcWidth  = 32;

   localparam logic [CrcWidth-1:0] CrcPoly   = 32'hEDB8_8320;
   localparam logic [CrcWidth-1:0] CrcInit   = 32'hFFFF_FFFF;
   localparam logic [CrcWidth-1:0] ZeroSubst = 32'd17;

   typedef logic [ByteWidth-1:0] byte_type;
   typedef logic [CrcWidth-1:0]  crc_type;

endpackage

FILE: sv/crc32bh_req_if.sv
// Input channel: one array byte per word, with present and last flags.
interface crc32bh_req_if;
   logic                    valid;
   logic                    ready;
   crc32bh_pkg::byte_type   data_byte;
   logic                    byte_present;
   logic                    last_byte;

   modport source (output valid, output data_byte, output byte_present,
                   output last_byte, input ready);
   modport sink   (input valid, input data_byte, input byte_present,
                   input last_byte, output ready);
endinterface

FILE: sv/crc32bh_rsp_if.sv
// Result channel: one 32-bit hash word per array.
interface crc32bh_rsp_if;
   logic                  valid;
   logic                  ready;
   crc32bh_pkg::crc_type  hash_value;

   modport source (output valid, output hash_value, input ready);
   modport sink   (input valid, input hash_value, output ready);
endinterface

FILE: sv/crc32_byte_hash_core.sv
// Top level of the byte-serial reflected CRC-32 array hash.
//
// Usage:
//   req_chan carries one byte of an array per word: data_byte, byte_present
//   (0 means the byte is ignored, e.g. for an empty array) and last_byte.
//   rsp_chan carries one hash_value word for each word marked last_byte:
//   the CRC register (init all ones, polynomial 0xEDB88320, no final
//   inversion), with 17 given in place of zero. The register then rearms.
// Timing:
//   One word accepted per cycle unless stalled (see Stall). A last word's
//   hash reaches rsp_chan through the input register, then the result
//   register. The rate is set by the unrolled eight-bit CRC fold, which
//   updates the state register once per cycle while words move on.
// Reset:
//   Synchronous, active high; clears both stages and loads all ones.
// Stall:
//   While a hash waits on rsp_chan, non-last words keep flowing; a second
//   last word holds in the input register and ready drops until the
//   pending hash is taken.
module crc32_byte_hash_core (
   input  logic           clock,
   input  logic           reset,
   crc32bh_req_if.sink    req_chan,
   crc32bh_rsp_if.source  rsp_chan
);

   crc32bh_core u_core (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

FILE: sv/crc32bh_fold.sv
// Byte fold logic: eight-bit unrolled reflected CRC step plus hash finish.
module crc32bh_fold (
   input  crc32bh_pkg::crc_type   crc_cur,
   input  crc32bh_pkg::byte_type  data_byte,
   input  logic                   byte_present,
   input  logic                   last_byte,
   output crc32bh_pkg::crc_type   crc_next,
   output crc32bh_pkg::crc_type   hash_value
);

   crc32bh_pkg::crc_type folded;
   crc32bh_pkg::crc_type crc_upd;

   always_comb begin
      crc32bh_pkg::crc_type idx;
      idx = {{(crc32bh_pkg::CrcWidth-crc32bh_pkg::ByteWidth){1'b0}},
             crc_cur[crc32bh_pkg::ByteWidth-1:0] ^ data_byte};
      for (int k = 0; k < crc32bh_pkg::ByteWidth; k++) begin
         if (idx[0]) begin
            idx = (idx >> 1) ^ crc32bh_pkg::CrcPoly;
         end else begin
            idx = idx >> 1;
         end
      end
      folded = (crc_cur >> crc32bh_pkg::ByteWidth) ^ idx;
   end

   assign crc_upd    = byte_present ? folded : crc_cur;
   assign hash_value = (crc_upd == '0) ? crc32bh_pkg::ZeroSubst : crc_upd;
   // end of array rearms the register for the next one
   assign crc_next   = last_byte ? crc32bh_pkg::CrcInit : crc_upd;

endmodule

FILE: sv/crc32bh_core.sv
// Two-stage datapath: input word register, CRC state and result register.
module crc32bh_core (
   input  logic                clock,
   input  logic                reset,
   crc32bh_req_if.sink         req_chan,
   crc32bh_rsp_if.source       rsp_chan
);

   logic                   s1_valid_ff, s1_valid_in;
   crc32bh_pkg::byte_type  s1_byte_ff;
   logic                   s1_present_ff;
   logic                   s1_last_ff;
   crc32bh_pkg::crc_type   crc_ff, crc_in;
   logic                   out_valid_ff, out_valid_in;
   crc32bh_pkg::crc_type   out_hash_ff;

   crc32bh_pkg::crc_type   crc_next;
   crc32bh_pkg::crc_type   hash_value;
   logic                   out_free;
   logic                   s1_go;
   logic                   req_take;

   crc32bh_fold u_fold (
      .crc_cur      (crc_ff),
      .data_byte    (s1_byte_ff),
      .byte_present (s1_present_ff),
      .last_byte    (s1_last_ff),
      .crc_next     (crc_next),
      .hash_value   (hash_value)
   );

   assign out_free = !out_valid_ff || rsp_chan.ready;
   // a non-last word never needs the result slot, so it always moves on
   assign s1_go    = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_chan.ready = !s1_valid_ff || s1_go;
   assign req_take = req_chan.valid && req_chan.ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_go);
   assign crc_in       = s1_go ? crc_next : crc_ff;
   assign out_valid_in = (s1_go && s1_last_ff) || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         crc_ff       <= crc32bh_pkg::CrcInit;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         crc_ff       <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff    <= req_chan.data_byte;
         s1_present_ff <= req_chan.byte_present;
         s1_last_ff    <= req_chan.last_byte;
      end
      if (s1_go && s1_last_ff) begin
         out_hash_ff <= hash_value;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.hash_value = out_hash_ff;

endmodule
